// ----- sv/aaf_pkg.sv -----
// ----------------------------------------------------------------------------
// aaf_pkg
// Shared types, codes and constants of the accumulator ALU with status flags.
// ----------------------------------------------------------------------------
package aaf_pkg;

  typedef enum logic [4:0] {
    ACT_ADC       = 5'd0,
    ACT_SBC       = 5'd1,
    ACT_AND       = 5'd2,
    ACT_ORA       = 5'd3,
    ACT_EOR       = 5'd4,
    ACT_BIT       = 5'd5,
    ACT_CMP       = 5'd6,
    ACT_INCM      = 5'd7,
    ACT_DECM      = 5'd8,
    ACT_INX       = 5'd9,
    ACT_DEX       = 5'd10,
    ACT_INY       = 5'd11,
    ACT_DEY       = 5'd12,
    ACT_ASL_A     = 5'd13,
    ACT_LSR_A     = 5'd14,
    ACT_ROL_A     = 5'd15,
    ACT_ROR_A     = 5'd16,
    ACT_ASL_M     = 5'd17,
    ACT_LSR_M     = 5'd18,
    ACT_ROL_M     = 5'd19,
    ACT_ROR_M     = 5'd20,
    ACT_LOADFLAGS = 5'd21,
    ACT_READST    = 5'd22,
    ACT_WRITEST   = 5'd23
  } aaf_action_e;

  typedef enum logic [1:0] {
    SHF_ASL = 2'd0,
    SHF_LSR = 2'd1,
    SHF_ROL = 2'd2,
    SHF_ROR = 2'd3
  } aaf_shift_e;

  // flag_bits layout, from bit 0 up: C Z I D B V N
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_V = 5;
  localparam int unsigned FLAG_N = 6;

  localparam logic [6:0] FLAGS_RESET = 7'b000_0100;
  localparam logic [7:0] SHIFT_CNT_MIN = 8'd1;
  localparam logic [7:0] SHIFT_CNT_MAX = 8'd8;
  localparam logic [4:0] ACT_SHIFT_BASE = 5'd13;

  typedef struct packed {
    logic [4:0]  action;
    logic [7:0]  value;
    logic [7:0]  compare_left;
    logic [7:0]  repeat_count;
    logic [15:0] mem_address;
  } aaf_item_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [6:0] flags;
  } aaf_state_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  status_out;
    logic        write_back;
    logic [7:0]  write_data;
    logic [15:0] write_address;
    logic        bad_count;
  } aaf_result_t;

  function automatic logic [7:0] pack_status(logic [6:0] flags);
    return {flags[FLAG_N], flags[FLAG_V], 1'b1, flags[FLAG_B:FLAG_C]};
  endfunction

endpackage

// ----- sv/aaf_if.sv -----
// ----------------------------------------------------------------------------
// aaf_if
// Valid/ready channels for operation transactions and result transactions.
// ----------------------------------------------------------------------------
interface aaf_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  action;
  logic [7:0]  value;
  logic [7:0]  compare_left;
  logic [7:0]  repeat_count;
  logic [15:0] mem_address;

  modport source (
    output valid, action, value, compare_left, repeat_count, mem_address,
    input  ready
  );
  modport sink (
    input  valid, action, value, compare_left, repeat_count, mem_address,
    output ready
  );
endinterface

interface aaf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic [7:0]  x_out;
  logic [7:0]  y_out;
  logic [7:0]  status_out;
  logic        write_back;
  logic [7:0]  write_data;
  logic [15:0] write_address;
  logic        bad_count;

  modport source (
    output valid, acc_out, x_out, y_out, status_out, write_back, write_data,
           write_address, bad_count,
    input  ready
  );
  modport sink (
    input  valid, acc_out, x_out, y_out, status_out, write_back, write_data,
           write_address, bad_count,
    output ready
  );
endinterface

// ----- sv/accumulator_alu_with_flags.sv -----
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags
// 8-bit accumulator ALU with X, Y and packed C Z I D B V N status flags.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_i    | in  | valid/ready  | action value compare_left repeat_count
//          |     |              | mem_address
//  out_o   | out | valid/ready  | acc_out x_out y_out status_out write_back
//          |     |              | write_data write_address bad_count
//
//  One transaction per cycle sustained while out_o is ready; the input register
//  feeds the result register, with the register file updated on the same edge.
//  Reset clears A, X, Y and all flags but I; no transaction is in flight.
//  A stalled result holds the result register; the input register still takes
//  a transaction and holds it until the result register frees up.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags (
  input  logic      clk_i,
  input  logic      rst_ni,
  aaf_in_if.sink    in_i,
  aaf_out_if.source out_o
);
  import aaf_pkg::*;

  logic        s1_valid_q;
  aaf_item_t   s1_item_q;
  logic        out_valid_q;
  aaf_result_t out_res_q;
  aaf_state_t  state_q;
  aaf_state_t  state_d;
  aaf_result_t res_d;
  logic        advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  aaf_alu u_alu (
    .item_i   (s1_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{acc: 8'd0, x: 8'd0, y: 8'd0, flags: FLAGS_RESET};
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= '{action:       in_i.action,
                     value:        in_i.value,
                     compare_left: in_i.compare_left,
                     repeat_count: in_i.repeat_count,
                     mem_address:  in_i.mem_address};
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.acc_out       = out_res_q.acc_out;
  assign out_o.x_out         = out_res_q.x_out;
  assign out_o.y_out         = out_res_q.y_out;
  assign out_o.status_out    = out_res_q.status_out;
  assign out_o.write_back    = out_res_q.write_back;
  assign out_o.write_data    = out_res_q.write_data;
  assign out_o.write_address = out_res_q.write_address;
  assign out_o.bad_count     = out_res_q.bad_count;

`ifndef SYNTHESIS
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("register state changed without a transaction");

  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_o.acc_out == state_q.acc) && (out_o.x_out == state_q.x) &&
                (out_o.y_out == state_q.y))
    else $error("result registers disagree with register state");

  a_bad_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_count |-> !out_o.write_back &&
                                      $past(state_q) == state_q)
    else $error("bad shift count changed state or wrote memory");

  a_no_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.write_back |->
      (out_o.write_data == 8'd0) && (out_o.write_address == 16'd0) &&
      out_o.status_out[5])
    else $error("idle write-back fields not cleared");
`endif

endmodule

// ----- sv/aaf_shift.sv -----
// ----------------------------------------------------------------------------
// aaf_shift
// Shifter for ASL, LSR, ROL and ROR by a count of 1 to 8, rotates through C.
// ----------------------------------------------------------------------------
module aaf_shift (
  input  aaf_pkg::aaf_shift_e kind_i,
  input  logic [7:0]          operand_i,
  input  logic                carry_i,
  input  logic [3:0]          count_i,
  output logic [7:0]          result_o,
  output logic                carry_o
);
  import aaf_pkg::*;

  logic [8:0]  wide;
  logic [17:0] twin;
  logic [8:0]  asl_r;
  logic [17:0] rol_r;
  logic [17:0] ror_r;
  logic [7:0]  lsr_r;
  logic [7:0]  lsr_c;
  logic [2:0]  cnt_m1;

  always_comb begin
    wide   = {carry_i, operand_i};
    twin   = {wide, wide};
    asl_r  = {1'b0, operand_i} << count_i;
    rol_r  = twin << count_i;
    ror_r  = twin >> count_i;
    lsr_r  = operand_i >> count_i;
    cnt_m1 = 3'(count_i - 4'd1);
    lsr_c  = operand_i >> cnt_m1;
    case (kind_i)
      SHF_ASL: begin
        result_o = asl_r[7:0];
        carry_o  = asl_r[8];
      end
      SHF_LSR: begin
        result_o = lsr_r;
        carry_o  = lsr_c[0];
      end
      SHF_ROL: begin
        result_o = rol_r[16:9];
        carry_o  = rol_r[17];
      end
      SHF_ROR: begin
        result_o = ror_r[7:0];
        carry_o  = ror_r[8];
      end
      default: begin
        result_o = operand_i;
        carry_o  = carry_i;
      end
    endcase
  end

endmodule

// ----- sv/aaf_alu.sv -----
// ----------------------------------------------------------------------------
// aaf_alu
// One-pass operation logic: next register state and the result transaction.
// ----------------------------------------------------------------------------
module aaf_alu (
  input  aaf_pkg::aaf_item_t   item_i,
  input  aaf_pkg::aaf_state_t  state_i,
  output aaf_pkg::aaf_state_t  state_o,
  output aaf_pkg::aaf_result_t result_o
);
  import aaf_pkg::*;

  aaf_action_e act;
  aaf_shift_e  kind;
  logic [7:0]  add_rhs;
  logic [8:0]  sum;
  logic [7:0]  diff;
  logic [7:0]  shf_in;
  logic [7:0]  shf_out;
  logic        shf_c;
  logic        cnt_ok;
  logic [4:0]  shf_off;
  logic [7:0]  tmp;
  logic        wb;
  logic [7:0]  wdata;
  logic        bad;

  assign act     = aaf_action_e'(item_i.action);
  assign shf_off = 5'(item_i.action - ACT_SHIFT_BASE);
  assign kind    = aaf_shift_e'(shf_off[1:0]);
  assign shf_in  = (act == ACT_ASL_M || act == ACT_LSR_M || act == ACT_ROL_M ||
                    act == ACT_ROR_M) ? item_i.value : state_i.acc;
  assign cnt_ok  = (item_i.repeat_count >= SHIFT_CNT_MIN) &&
                   (item_i.repeat_count <= SHIFT_CNT_MAX);
  assign add_rhs = (act == ACT_SBC) ? ~item_i.value : item_i.value;
  assign sum     = {1'b0, state_i.acc} + {1'b0, add_rhs} +
                   {8'd0, state_i.flags[FLAG_C]};
  assign diff    = item_i.compare_left - item_i.value;

  aaf_shift u_shift (
    .kind_i    (kind),
    .operand_i (shf_in),
    .carry_i   (state_i.flags[FLAG_C]),
    .count_i   (item_i.repeat_count[3:0]),
    .result_o  (shf_out),
    .carry_o   (shf_c)
  );

  always_comb begin
    state_o = state_i;
    wb      = 1'b0;
    wdata   = 8'd0;
    bad     = 1'b0;
    tmp     = 8'd0;
    case (act)
      ACT_ADC, ACT_SBC: begin
        state_o.acc          = sum[7:0];
        state_o.flags[FLAG_C] = sum[8];
        state_o.flags[FLAG_V] = (sum[7] ^ state_i.acc[7]) & (sum[7] ^ add_rhs[7]);
        state_o.flags[FLAG_Z] = (sum[7:0] == 8'd0);
        state_o.flags[FLAG_N] = sum[7];
      end
      ACT_AND, ACT_ORA, ACT_EOR: begin
        if (act == ACT_AND) begin
          tmp = state_i.acc & item_i.value;
        end else if (act == ACT_ORA) begin
          tmp = state_i.acc | item_i.value;
        end else begin
          tmp = state_i.acc ^ item_i.value;
        end
        state_o.acc           = tmp;
        state_o.flags[FLAG_Z] = (tmp == 8'd0);
        state_o.flags[FLAG_N] = tmp[7];
      end
      ACT_BIT: begin
        state_o.flags[FLAG_Z] = ((state_i.acc & item_i.value) == 8'd0);
        state_o.flags[FLAG_V] = item_i.value[6];
        state_o.flags[FLAG_N] = item_i.value[7];
      end
      ACT_CMP: begin
        state_o.flags[FLAG_C] = (item_i.compare_left >= item_i.value);
        state_o.flags[FLAG_Z] = (item_i.compare_left == item_i.value);
        state_o.flags[FLAG_N] = diff[7];
      end
      ACT_INCM, ACT_DECM: begin
        tmp = (act == ACT_INCM) ? item_i.value + item_i.repeat_count
                                : item_i.value - item_i.repeat_count;
        wb    = 1'b1;
        wdata = tmp;
        state_o.flags[FLAG_Z] = (tmp == 8'd0);
        state_o.flags[FLAG_N] = tmp[7];
      end
      ACT_INX, ACT_DEX: begin
        tmp = (act == ACT_INX) ? state_i.x + item_i.repeat_count
                               : state_i.x - item_i.repeat_count;
        state_o.x             = tmp;
        state_o.flags[FLAG_Z] = (tmp == 8'd0);
        state_o.flags[FLAG_N] = tmp[7];
      end
      ACT_INY, ACT_DEY: begin
        tmp = (act == ACT_INY) ? state_i.y + item_i.repeat_count
                               : state_i.y - item_i.repeat_count;
        state_o.y             = tmp;
        state_o.flags[FLAG_Z] = (tmp == 8'd0);
        state_o.flags[FLAG_N] = tmp[7];
      end
      ACT_ASL_A, ACT_LSR_A, ACT_ROL_A, ACT_ROR_A,
      ACT_ASL_M, ACT_LSR_M, ACT_ROL_M, ACT_ROR_M: begin
        if (!cnt_ok) begin
          bad = 1'b1;
        end else begin
          state_o.flags[FLAG_C] = shf_c;
          state_o.flags[FLAG_Z] = (shf_out == 8'd0);
          state_o.flags[FLAG_N] = shf_out[7];
          if (act == ACT_ASL_A || act == ACT_LSR_A || act == ACT_ROL_A ||
              act == ACT_ROR_A) begin
            state_o.acc = shf_out;
          end else begin
            wb    = 1'b1;
            wdata = shf_out;
          end
        end
      end
      ACT_LOADFLAGS: begin
        state_o.flags[FLAG_Z] = (item_i.value == 8'd0);
        state_o.flags[FLAG_N] = item_i.value[7];
      end
      ACT_READST: begin
        state_o = state_i;
      end
      ACT_WRITEST: begin
        state_o.flags = {item_i.value[7:6], item_i.value[4:0]};
      end
      default: begin
        state_o = state_i;
      end
    endcase

    result_o.acc_out       = state_o.acc;
    result_o.x_out         = state_o.x;
    result_o.y_out         = state_o.y;
    result_o.status_out    = pack_status(state_o.flags);
    result_o.write_back    = wb;
    result_o.write_data    = wdata;
    result_o.write_address = wb ? item_i.mem_address : 16'd0;
    result_o.bad_count     = bad;
  end

endmodule

// ----- verif/alu_flag_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_flag_checker
// Watches the operation and result channels of the accumulator ALU, runs its
// own copy of A, X, Y and the status flags on every accepted operation, and
// compares each accepted result with the oldest outcome still owed.
// ----------------------------------------------------------------------------
module alu_flag_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  aaf_in_if           op_mon,
  aaf_out_if          res_mon,
  output int unsigned fail_count_o,
  output int unsigned owed_count_o,
  output int unsigned compared_count_o
);
  import aaf_pkg::*;

  logic [7:0]  acc_q;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic [6:0]  flags_q;
  aaf_result_t alu_outcomes_q[$];
  int unsigned fails    = 0;
  int unsigned owed     = 0;
  int unsigned compared = 0;

  assign fail_count_o     = fails;
  assign owed_count_o     = owed;
  assign compared_count_o = compared;

  function automatic logic [6:0] with_zn(input logic [6:0] f, input logic [7:0] v);
    f[FLAG_Z] = (v == 8'h00);
    f[FLAG_N] = v[7];
    return f;
  endfunction

  function automatic logic [7:0] shift_byte(input aaf_shift_e kind, input logic [7:0] v,
                                            input logic [3:0] n, input logic cin,
                                            output logic cout);
    logic [8:0] w;
    logic [8:0] r;
    w = {cin, v};
    case (kind)
      SHF_ASL: begin
        r    = {1'b0, v} << n;
        cout = r[8];
      end
      SHF_LSR: begin
        r    = {1'b0, v >> n};
        cout = v[n - 4'd1];
      end
      SHF_ROL: begin
        r    = (w << n) | (w >> (4'd9 - n));
        cout = r[8];
      end
      default: begin
        r    = (w >> n) | (w << (4'd9 - n));
        cout = r[8];
      end
    endcase
    return r[7:0];
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      fails++;
    end
  endfunction

  task automatic exec_alu_op(input aaf_item_t op, output aaf_result_t res);
    logic [8:0] sum;
    logic [7:0] addend;
    logic [7:0] diff;
    logic [7:0] wdata;
    logic [7:0] sres;
    logic [7:0] src;
    logic [4:0] offset;
    logic       wb;
    logic       bad;
    logic       cout;
    wb    = 1'b0;
    bad   = 1'b0;
    wdata = 8'h00;
    case (op.action)
      ACT_ADC, ACT_SBC: begin
        addend = (op.action == ACT_SBC) ? ~op.value : op.value;
        sum    = {1'b0, acc_q} + {1'b0, addend} + {8'd0, flags_q[FLAG_C]};
        flags_q[FLAG_C] = sum[8];
        flags_q[FLAG_V] = (sum[7] ^ acc_q[7]) & (sum[7] ^ addend[7]);
        acc_q   = sum[7:0];
        flags_q = with_zn(flags_q, acc_q);
      end
      ACT_AND: begin
        acc_q   = acc_q & op.value;
        flags_q = with_zn(flags_q, acc_q);
      end
      ACT_ORA: begin
        acc_q   = acc_q | op.value;
        flags_q = with_zn(flags_q, acc_q);
      end
      ACT_EOR: begin
        acc_q   = acc_q ^ op.value;
        flags_q = with_zn(flags_q, acc_q);
      end
      ACT_BIT: begin
        flags_q[FLAG_Z] = ((acc_q & op.value) == 8'h00);
        flags_q[FLAG_V] = op.value[6];
        flags_q[FLAG_N] = op.value[7];
      end
      ACT_CMP: begin
        diff = op.compare_left - op.value;
        flags_q[FLAG_C] = (op.compare_left >= op.value);
        flags_q[FLAG_Z] = (op.compare_left == op.value);
        flags_q[FLAG_N] = diff[7];
      end
      ACT_INCM: begin
        wdata   = op.value + op.repeat_count;
        flags_q = with_zn(flags_q, wdata);
        wb      = 1'b1;
      end
      ACT_DECM: begin
        wdata   = op.value - op.repeat_count;
        flags_q = with_zn(flags_q, wdata);
        wb      = 1'b1;
      end
      ACT_INX: begin
        x_q     = x_q + op.repeat_count;
        flags_q = with_zn(flags_q, x_q);
      end
      ACT_DEX: begin
        x_q     = x_q - op.repeat_count;
        flags_q = with_zn(flags_q, x_q);
      end
      ACT_INY: begin
        y_q     = y_q + op.repeat_count;
        flags_q = with_zn(flags_q, y_q);
      end
      ACT_DEY: begin
        y_q     = y_q - op.repeat_count;
        flags_q = with_zn(flags_q, y_q);
      end
      ACT_ASL_A, ACT_LSR_A, ACT_ROL_A, ACT_ROR_A,
      ACT_ASL_M, ACT_LSR_M, ACT_ROL_M, ACT_ROR_M: begin
        if (op.repeat_count < SHIFT_CNT_MIN || op.repeat_count > SHIFT_CNT_MAX) begin
          bad = 1'b1;
        end else begin
          offset = op.action - ACT_SHIFT_BASE;
          src    = (op.action <= ACT_ROR_A) ? acc_q : op.value;
          sres   = shift_byte(aaf_shift_e'(offset[1:0]), src, op.repeat_count[3:0],
                              flags_q[FLAG_C], cout);
          flags_q[FLAG_C] = cout;
          flags_q = with_zn(flags_q, sres);
          if (op.action <= ACT_ROR_A) begin
            acc_q = sres;
          end else begin
            wdata = sres;
            wb    = 1'b1;
          end
        end
      end
      ACT_LOADFLAGS: begin
        flags_q = with_zn(flags_q, op.value);
      end
      ACT_WRITEST: begin
        flags_q = {op.value[7], op.value[6], op.value[4:0]};
      end
      default: begin
      end
    endcase
    res.acc_out       = acc_q;
    res.x_out         = x_q;
    res.y_out         = y_q;
    res.status_out    = {flags_q[FLAG_N], flags_q[FLAG_V], 1'b1, flags_q[FLAG_B],
                         flags_q[FLAG_D], flags_q[FLAG_I], flags_q[FLAG_Z], flags_q[FLAG_C]};
    res.write_back    = wb;
    res.write_data    = wb ? wdata : 8'h00;
    res.write_address = wb ? op.mem_address : 16'h0000;
    res.bad_count     = bad;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    aaf_item_t   op;
    aaf_result_t want;
    aaf_result_t seen;
    if (!rst_ni) begin
      acc_q   = 8'h00;
      x_q     = 8'h00;
      y_q     = 8'h00;
      flags_q = FLAGS_RESET;
      alu_outcomes_q.delete();
      owed    = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        seen = {res_mon.acc_out, res_mon.x_out, res_mon.y_out, res_mon.status_out,
                res_mon.write_back, res_mon.write_data, res_mon.write_address,
                res_mon.bad_count};
        if (alu_outcomes_q.size() == 0) begin
          $error("result transaction arrived with no outcome owed");
          fails++;
        end else begin
          want = alu_outcomes_q.pop_front();
          check_field("acc_out", 16'(want.acc_out), 16'(seen.acc_out));
          check_field("x_out", 16'(want.x_out), 16'(seen.x_out));
          check_field("y_out", 16'(want.y_out), 16'(seen.y_out));
          check_field("status_out", 16'(want.status_out), 16'(seen.status_out));
          check_field("write_back", 16'(want.write_back), 16'(seen.write_back));
          check_field("write_data", 16'(want.write_data), 16'(seen.write_data));
          check_field("write_address", want.write_address, seen.write_address);
          check_field("bad_count", 16'(want.bad_count), 16'(seen.bad_count));
          compared++;
        end
      end
      if (op_mon.valid && op_mon.ready) begin
        op = {op_mon.action, op_mon.value, op_mon.compare_left, op_mon.repeat_count,
              op_mon.mem_address};
        exec_alu_op(op, want);
        alu_outcomes_q = {alu_outcomes_q, want};
      end
      owed = alu_outcomes_q.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the accumulator ALU with a directed sweep of every action, the edge
// operands and the bad shift counts, then random operation streams under three
// idle mixes on both channels; a checker beside the block scores every result.
// ----------------------------------------------------------------------------
module testbench;
  import aaf_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned ops_sent = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_count;
  int unsigned owed_count;
  int unsigned compared_count;

  aaf_in_if  op_ch ();
  aaf_out_if res_ch ();

  accumulator_alu_with_flags i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  alu_flag_checker i_alu_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .op_mon           (op_ch),
    .res_mon          (res_ch),
    .fail_count_o     (fail_count),
    .owed_count_o     (owed_count),
    .compared_count_o (compared_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Enter and leave at a falling edge.
  task automatic send_op(input logic [4:0] act, input logic [7:0] val,
                         input logic [7:0] left, input logic [7:0] cnt,
                         input logic [15:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      op_ch.valid        <= 1'b0;
      op_ch.action       <= 5'($urandom_range(31));
      op_ch.value        <= rand_byte();
      op_ch.compare_left <= rand_byte();
      op_ch.repeat_count <= rand_byte();
      op_ch.mem_address  <= 16'($urandom_range(65535));
      @(negedge clk);
    end
    op_ch.valid        <= 1'b1;
    op_ch.action       <= act;
    op_ch.value        <= val;
    op_ch.compare_left <= left;
    op_ch.repeat_count <= cnt;
    op_ch.mem_address  <= addr;
    do @(posedge clk); while (!op_ch.ready);
    ops_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain_results();
    op_ch.valid <= 1'b0;
    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
  endtask

  task automatic send_random_op(output bit counted);
    logic [4:0] act;
    logic [7:0] cnt;
    if ($urandom_range(99) < 3) begin
      act = 5'(24 + $urandom_range(7));
    end else begin
      act = 5'($urandom_range(23));
    end
    if (act >= ACT_ASL_A && act <= ACT_ROR_M && $urandom_range(99) < 80) begin
      cnt = 8'($urandom_range(8, 1));
    end else begin
      cnt = rand_byte();
    end
    send_op(act, rand_byte(), rand_byte(), cnt, 16'($urandom_range(65535)));
    counted = (act <= ACT_WRITEST);
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input int unsigned n_ops);
    int unsigned done_ops;
    bit          counted;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    done_ops     = 0;
    while (done_ops < n_ops) begin
      send_random_op(counted);
      if (counted) begin
        done_ops++;
        if (done_ops % 250 == 0) drain_results();
      end
    end
    drain_results();
  endtask

  initial begin
    rst_n              = 1'b0;
    op_ch.valid        = 1'b0;
    op_ch.action       = ACT_READST;
    op_ch.value        = 8'h00;
    op_ch.compare_left = 8'h00;
    op_ch.repeat_count = 8'h00;
    op_ch.mem_address  = 16'h0000;
    src_idle_pct       = 23;
    snk_idle_pct       = 78;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_op(ACT_READST,    8'h00, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_WRITEST,   8'hDF, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_ADC,       8'hFF, 8'h00, 8'h00, 16'hFFFF);
    send_op(ACT_ADC,       8'h7F, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_SBC,       8'h00, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_SBC,       8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_op(ACT_AND,       8'h0F, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_ORA,       8'hF0, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_EOR,       8'hFF, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_BIT,       8'hC0, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_CMP,       8'hFF, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_CMP,       8'hFF, 8'hFF, 8'h00, 16'h0000);
    send_op(ACT_INCM,      8'hFF, 8'h00, 8'h01, 16'hFFFF);
    send_op(ACT_DECM,      8'h00, 8'h00, 8'hFF, 16'h0000);
    send_op(ACT_INX,       8'h00, 8'h00, 8'hFF, 16'h0000);
    send_op(ACT_DEX,       8'h00, 8'h00, 8'h01, 16'h0000);
    send_op(ACT_INY,       8'h00, 8'h00, 8'h80, 16'h0000);
    send_op(ACT_DEY,       8'h00, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_ASL_A,     8'h00, 8'h00, 8'h08, 16'h0000);
    send_op(ACT_LSR_A,     8'h00, 8'h00, 8'h01, 16'h0000);
    send_op(ACT_ROL_A,     8'h00, 8'h00, 8'h08, 16'h0000);
    send_op(ACT_ROR_A,     8'h00, 8'h00, 8'h01, 16'h0000);
    send_op(ACT_ASL_M,     8'hFF, 8'h00, 8'h00, 16'h1234);
    send_op(ACT_ROR_M,     8'hFF, 8'h00, 8'hFF, 16'h4321);
    send_op(ACT_LSR_M,     8'h80, 8'h00, 8'h09, 16'h5A5A);
    send_op(ACT_ROL_M,     8'h81, 8'h00, 8'h08, 16'hA5A5);
    send_op(ACT_LOADFLAGS, 8'h80, 8'h00, 8'h00, 16'h0000);
    send_op(ACT_WRITEST,   8'h20, 8'h00, 8'h00, 16'h0000);
    send_op(5'd31,         8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    drain_results();

    run_phase(23, 78, 617);
    run_phase(78, 23, 617);
    run_phase(0, 0, 616);
    repeat (8) @(negedge clk);

    $display("Covered %0d operation transactions: all 32 action codes, shift counts 0 to 255,",
             ops_sent);
    $display("three idle mixes on both channels; %0d result transactions compared.",
             compared_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/aaf_pkg.sv
sv/aaf_if.sv
sv/aaf_shift.sv
sv/aaf_alu.sv
sv/accumulator_alu_with_flags.sv
verif/alu_flag_checker.sv
verif/testbench.sv
